@@ hdl/cstc_pkg.sv @@
package cstc_pkg;

   localparam int FX_W      = 16;
   localparam int FRAC_BITS = 15;
   localparam int PROD_W    = 2 * FX_W;
   localparam int WIDE_W    = FX_W + 2;
   localparam int REM_W     = FX_W + 1;
   localparam int NUM_CHAN  = 3;

   localparam int DIV_BITS_PER_STAGE = 2;

   localparam logic [FX_W-1:0] ONE_FX = FX_W'(1 << FRAC_BITS);

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INK_RED      = 2'd0,
      CSR_INK_GREEN    = 2'd1,
      CSR_INK_BLUE     = 2'd2,
      CSR_ALPHA_LOCKED = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [FX_W-1:0] dst_red;
      logic [FX_W-1:0] dst_green;
      logic [FX_W-1:0] dst_blue;
      logic [FX_W-1:0] dst_alpha;
      logic [FX_W-1:0] stroke_alpha;
      logic [FX_W-1:0] weight;
      logic [FX_W-1:0] ceiling;
   } req_type;

   typedef struct packed {
      logic [FX_W-1:0] out_red;
      logic [FX_W-1:0] out_green;
      logic [FX_W-1:0] out_blue;
      logic [FX_W-1:0] out_alpha;
      logic [FX_W-1:0] new_stroke_alpha;
      logic [FX_W-1:0] dab_alpha;
      logic            deposited;
   } rsp_type;

   // travels alongside the quotient through the divider
   typedef struct packed {
      req_type         raw;
      logic [FX_W-1:0] a1;
      logic            refuse;
   } side_type;

   function automatic logic [FX_W-1:0] sat_one(input logic [FX_W-1:0] v);
      return (v > ONE_FX) ? ONE_FX : v;
   endfunction

   function automatic logic [FX_W-1:0] sat_wide(input logic [WIDE_W-1:0] v);
      return (v > WIDE_W'(ONE_FX)) ? ONE_FX : v[FX_W-1:0];
   endfunction

endpackage

@@ hdl/capped_stroke_texel_composite.sv @@
// Channel    Ports                               Direction
// request    req_valid, req_stall, req_data      in
// response   rsp_valid, rsp_stall, rsp_data      out
// csr        csr_valid, csr_ready, csr_index,    in, write only
//            csr_data
//
// One request per cycle while req_stall is low; each response passes through
// 3 front stages, the 8-stage divider (2 quotient bits a stage)
// and 3 blend stages.
// Reset clears the pipeline valid bits and the csr registers.
// A stage holds while its successor is full and held; req_stall rises only
// when every stage back to the input register is full.
module capped_stroke_texel_composite
   import cstc_pkg::*;
#(
   parameter int DIV_STEP_BITS = DIV_BITS_PER_STAGE
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FX_W-1:0]      csr_data
);

   localparam int DIV_N     = FX_W / DIV_STEP_BITS;
   localparam int DIV_FIRST = 4;
   localparam int NSTG      = DIV_N + 6;

   typedef struct packed {
      req_type         raw;
      logic [FX_W-1:0] a0;
      logic [FX_W-1:0] cap;
      logic [FX_W-1:0] head;
      logic [PROD_W-1:0] prod;
      logic            refuse;
   } s2_type;

   typedef struct packed {
      side_type        side;
      logic [FX_W-1:0] num;
      logic [FX_W-1:0] head;
   } s3_type;

   typedef struct packed {
      req_type                          raw;
      logic [FX_W-1:0]                  a1;
      logic [FX_W-1:0]                  a;
      logic [FX_W-1:0]                  dac;
      logic                             refuse;
      logic [NUM_CHAN-1:0][PROD_W-1:0]  p_ink;
      logic [NUM_CHAN-1:0][PROD_W-1:0]  p_dst;
      logic [PROD_W-1:0]                p_da;
   } s12_type;

   typedef struct packed {
      req_type                          raw;
      logic [FX_W-1:0]                  a1;
      logic [FX_W-1:0]                  a;
      logic                             refuse;
      logic [NUM_CHAN-1:0][PROD_W-1:0]  p_dst;
      logic [NUM_CHAN-1:0][PROD_W-1:0]  pt;
      logic [NUM_CHAN-1:0][FX_W-1:0]    norm;
      logic [FX_W-1:0]                  alpha_n;
   } s13_type;

   // csr
   logic [NUM_CHAN-1:0][FX_W-1:0] ink_ff;
   logic                          lock_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ink_ff  <= '0;
         lock_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_INK_RED:      ink_ff[0] <= csr_data;
            CSR_INK_GREEN:    ink_ff[1] <= csr_data;
            CSR_INK_BLUE:     ink_ff[2] <= csr_data;
            CSR_ALPHA_LOCKED: lock_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic [NSTG:1] v_ff;
   logic [NSTG:1] v_in;
   logic [NSTG:1] v_prev;
   logic [NSTG:1] adv;

   assign v_prev = {v_ff[NSTG-1:1], req_valid};

   always_comb begin
      adv[NSTG] = !v_ff[NSTG] || !rsp_stall;
      for (int k = NSTG - 1; k >= 1; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign v_in      = (adv & v_prev) | (~adv & v_ff);
   assign req_stall = !adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // stage 1: input register
   req_type s1_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_ff <= req_data;
      end
   end

   // stage 2: saturate, refusal checks, w * (1 - a0)
   s2_type          s2_in, s2_ff;
   logic [FX_W-1:0] w_sat;

   always_comb begin
      w_sat       = sat_one(s1_ff.weight);
      s2_in.raw   = s1_ff;
      s2_in.a0    = sat_one(s1_ff.stroke_alpha);
      s2_in.cap   = sat_one(s1_ff.ceiling);
      s2_in.head  = ONE_FX - s2_in.a0;
      s2_in.prod  = PROD_W'(w_sat) * PROD_W'(s2_in.head);
      s2_in.refuse = (w_sat == '0) || (s2_in.cap == '0) || (s2_in.head == '0)
                     || (s2_in.a0 >= s2_in.cap);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_ff <= s2_in;
      end
   end

   // stage 3: capped new stroke alpha
   s3_type           s3_in, s3_ff;
   logic [FX_W:0]    a1_sum;

   always_comb begin
      a1_sum = {1'b0, s2_ff.a0} + s2_ff.prod[FRAC_BITS +: FX_W+1];
      s3_in.side.raw    = s2_ff.raw;
      s3_in.side.refuse = s2_ff.refuse;
      s3_in.side.a1     = (a1_sum > {1'b0, s2_ff.cap}) ? s2_ff.cap : a1_sum[FX_W-1:0];
      s3_in.num         = s3_in.side.a1 - s2_ff.a0;
      s3_in.head        = s2_ff.head;
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_ff <= s3_in;
      end
   end

   // stages 4..11: (a1 - a0) / (1 - a0)
   logic [FX_W-1:0] quot;
   side_type        div_side;

   cstc_div_pipe #(
      .STEP_BITS (DIV_STEP_BITS)
   ) u_div (
      .clock    (clock),
      .stage_en (adv[DIV_FIRST +: DIV_N]),
      .num      (s3_ff.num),
      .den      (s3_ff.head),
      .side_in  (s3_ff.side),
      .quot     (quot),
      .side_out (div_side)
   );

   // stage 12: blend products
   s12_type                       s12_in, s12_ff;
   logic [FX_W-1:0]               keep;
   logic [NUM_CHAN-1:0][FX_W-1:0] dst_col;

   assign dst_col = {div_side.raw.dst_blue, div_side.raw.dst_green, div_side.raw.dst_red};

   always_comb begin
      s12_in.raw    = div_side.raw;
      s12_in.a1     = div_side.a1;
      s12_in.a      = sat_one(quot);
      s12_in.refuse = div_side.refuse || (s12_in.a == '0);
      s12_in.dac    = sat_one(div_side.raw.dst_alpha);
      keep          = ONE_FX - s12_in.a;
      for (int c = 0; c < NUM_CHAN; c++) begin
         s12_in.p_ink[c] = PROD_W'(sat_one(ink_ff[c])) * PROD_W'(s12_in.a);
         s12_in.p_dst[c] = PROD_W'(sat_one(dst_col[c])) * PROD_W'(keep);
      end
      s12_in.p_da = PROD_W'(s12_in.dac) * PROD_W'(keep);
   end

   always_ff @(posedge clock) begin
      if (adv[DIV_FIRST + DIV_N]) begin
         s12_ff <= s12_in;
      end
   end

   // stage 13: normal sums, locked ink times dst alpha
   s13_type           s13_in, s13_ff;
   logic [PROD_W-1:0] norm_sum;

   always_comb begin
      s13_in.raw    = s12_ff.raw;
      s13_in.a1     = s12_ff.a1;
      s13_in.a      = s12_ff.a;
      s13_in.refuse = s12_ff.refuse;
      s13_in.p_dst  = s12_ff.p_dst;
      norm_sum      = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         s13_in.pt[c]   = PROD_W'(s12_ff.p_ink[c][FRAC_BITS +: FX_W]) * PROD_W'(s12_ff.dac);
         norm_sum       = s12_ff.p_ink[c] + s12_ff.p_dst[c];
         s13_in.norm[c] = sat_wide(WIDE_W'(norm_sum[PROD_W-1:FRAC_BITS]));
      end
      s13_in.alpha_n = sat_wide(WIDE_W'(s12_ff.a) + WIDE_W'(s12_ff.p_da[FRAC_BITS +: FX_W]));
   end

   always_ff @(posedge clock) begin
      if (adv[NSTG-1]) begin
         s13_ff <= s13_in;
      end
   end

   // stage 14: output register
   rsp_type                       s14_in, s14_ff;
   logic [NUM_CHAN-1:0][FX_W-1:0] col;
   logic [PROD_W:0]               lock_sum;

   always_comb begin
      lock_sum = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         lock_sum = {1'b0, s13_ff.p_dst[c]} + {1'b0, s13_ff.pt[c]};
         col[c]   = lock_ff ? sat_wide(lock_sum[PROD_W:FRAC_BITS]) : s13_ff.norm[c];
      end
      if (s13_ff.refuse) begin
         s14_in.out_red          = s13_ff.raw.dst_red;
         s14_in.out_green        = s13_ff.raw.dst_green;
         s14_in.out_blue         = s13_ff.raw.dst_blue;
         s14_in.out_alpha        = s13_ff.raw.dst_alpha;
         s14_in.new_stroke_alpha = s13_ff.raw.stroke_alpha;
         s14_in.dab_alpha        = '0;
         s14_in.deposited        = 1'b0;
      end else begin
         s14_in.out_red          = col[0];
         s14_in.out_green        = col[1];
         s14_in.out_blue         = col[2];
         s14_in.out_alpha        = lock_ff ? s13_ff.raw.dst_alpha : s13_ff.alpha_n;
         s14_in.new_stroke_alpha = s13_ff.a1;
         s14_in.dab_alpha        = s13_ff.a;
         s14_in.deposited        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NSTG]) begin
         s14_ff <= s14_in;
      end
   end

   assign rsp_valid = v_ff[NSTG];
   assign rsp_data  = s14_ff;

endmodule

@@ hdl/cstc_div_pipe.sv @@
module cstc_div_pipe
   import cstc_pkg::*;
#(
   parameter int STEP_BITS = DIV_BITS_PER_STAGE
)
(
   input  logic                      clock,
   input  logic [FX_W/STEP_BITS-1:0] stage_en,
   input  logic [FX_W-1:0]           num,
   input  logic [FX_W-1:0]           den,
   input  side_type                  side_in,
   output logic [FX_W-1:0]           quot,
   output side_type                  side_out
);

   localparam int STAGES = FX_W / STEP_BITS;

   logic [REM_W-1:0] rem_ff  [STAGES];
   logic [FX_W-1:0]  quo_ff  [STAGES];
   logic [FX_W-1:0]  den_ff  [STAGES];
   side_type         side_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic [REM_W-1:0] rem_src;
      logic [FX_W-1:0]  quo_src;
      logic [FX_W-1:0]  den_src;
      side_type         side_src;
      logic [REM_W-1:0] rem_in;
      logic [FX_W-1:0]  quo_in;

      if (i == 0) begin : g_first
         assign rem_src  = {1'b0, num};
         assign quo_src  = '0;
         assign den_src  = den;
         assign side_src = side_in;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign quo_src  = quo_ff[i-1];
         assign den_src  = den_ff[i-1];
         assign side_src = side_ff[i-1];
      end

      // restoring division, one quotient bit per step
      always_comb begin
         rem_in = rem_src;
         quo_in = quo_src;
         for (int b = 0; b < STEP_BITS; b++) begin
            if (rem_in >= {1'b0, den_src}) begin
               rem_in = rem_in - {1'b0, den_src};
               quo_in = {quo_in[FX_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_in[FX_W-2:0], 1'b0};
            end
            rem_in = {rem_in[REM_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[i]) begin
            rem_ff[i]  <= rem_in;
            quo_ff[i]  <= quo_in;
            den_ff[i]  <= den_src;
            side_ff[i] <= side_src;
         end
      end
   end

   assign quot     = quo_ff[STAGES-1];
   assign side_out = side_ff[STAGES-1];

endmodule

@@ hdl/cstc_checker.sv @@
module cstc_checker
   import cstc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_refused_no_dab: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.deposited |-> rsp_data.dab_alpha == '0)
      else $error("refused request carries dab alpha");

   a_deposit_dab: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.deposited |-> rsp_data.dab_alpha != '0
         && rsp_data.dab_alpha <= ONE_FX && rsp_data.new_stroke_alpha != '0)
      else $error("deposit with bad dab or stroke alpha");

   a_deposit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.deposited |-> rsp_data.out_red <= ONE_FX
         && rsp_data.out_green <= ONE_FX && rsp_data.out_blue <= ONE_FX
         && rsp_data.new_stroke_alpha <= ONE_FX)
      else $error("deposit result above one");

endmodule

bind capped_stroke_texel_composite cstc_checker u_cstc_checker (.*);
